FILE: rtl/core/plsu_pkg.sv
// ============================================================================
// plsu_pkg
// Shared types and constants of the positional list store unit.
// ============================================================================
package plsu_pkg;

   // Sizes of the defaults and of the fixed item fields
   localparam int CAPACITY_DEFAULT   = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int MODE_W             = 3;
   localparam int POS_W              = 7;
   localparam int ENTRY_W            = 32;
   localparam int COUNT_OUT_W        = 7;
   localparam int MAX_ENTRIES_W      = 7;

   // Leaves per group of the read-out tree
   localparam int GROUP_SIZE = 32;

   // max_entries after reset
   localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RESET = 7'd64;

   // Operation codes carried in the request's tuser
   localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic do_insert;   // cells above the position take the left neighbor
      logic do_remove;   // cells at or above the position take the right neighbor
      logic do_write;    // cell at the position takes the new word
   } cell_cmd_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_GATHER = 2'b10
   } state_type;

endpackage

FILE: rtl/core/plsu_cell.sv
// ============================================================================
// plsu_cell
// One list entry; shifts with its neighbors on insert and remove.
// ============================================================================
module plsu_cell #(
   parameter int DATA_WIDTH = plsu_pkg::DATA_WIDTH_DEFAULT,
   parameter int IDX_W      = 8,
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  plsu_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0]       idx,
   input  logic [DATA_WIDTH-1:0]  word,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [DATA_WIDTH-1:0]  data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // next entry value
   always_comb begin
      data_in = data_ff;
      if (cmd.do_insert && (MY_IDX > idx)) begin
         data_in = left_data;
      end else if (cmd.do_remove && (MY_IDX >= idx)) begin
         data_in = right_data;
      end
      if ((cmd.do_insert || cmd.do_write) && (MY_IDX == idx)) begin
         data_in = word;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: rtl/core/plsu_gather.sv
// ============================================================================
// plsu_gather
// Two-level read-out tree over the cell chain; the first level is registered.
// ============================================================================
module plsu_gather #(
   parameter int DATA_WIDTH = plsu_pkg::DATA_WIDTH_DEFAULT,
   parameter int CAPACITY   = plsu_pkg::CAPACITY_DEFAULT,
   parameter int NG_W       = 1
) (
   input  logic                       clock,
   input  logic                       load,
   input  logic [DATA_WIDTH-1:0]      cells [CAPACITY],
   input  logic [NG_W+$clog2(plsu_pkg::GROUP_SIZE)-1:0] idx,
   output logic [DATA_WIDTH-1:0]      word
);

   localparam int GS    = plsu_pkg::GROUP_SIZE;
   localparam int GRP_W = $clog2(plsu_pkg::GROUP_SIZE);
   localparam int NGP   = 1 << NG_W;

   logic [DATA_WIDTH-1:0] padded [NGP][GS];
   logic [DATA_WIDTH-1:0] group_ff [NGP];
   logic [NG_W-1:0]       hi_ff;
   logic [GRP_W-1:0]      lo_idx;

   // leaves past the last cell read as zero
   for (genvar k = 0; k < NGP * GS; k++) begin : g_pad
      if (k < CAPACITY) begin : g_live
         assign padded[k / GS][k % GS] = cells[k];
      end else begin : g_zero
         assign padded[k / GS][k % GS] = '0;
      end
   end

   assign lo_idx = idx[GRP_W-1:0];

   // first level: one pick per group, taken when the item is accepted
   always_ff @(posedge clock) begin
      if (load) begin
         for (int g = 0; g < NGP; g++) begin
            group_ff[g] <= padded[g][lo_idx];
         end
         hi_ff <= idx[NG_W+GRP_W-1:GRP_W];
      end
   end

   // second level: pick the group
   assign word = group_ff[hi_ff];

endmodule

FILE: rtl/core/positional_list_store_unit.sv
// ============================================================================
// positional_list_store_unit
// Ordered list of data words addressed by 1-based position, held in a chain.
// ============================================================================
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser mode; tdata position, entry_value
//  rsp      out  rsp_tvalid/rsp_tready  tdata ok, read_value, entry_count, is_empty
//  csr      in   csr_valid/csr_ready    csr_data max_entries
//
//  An item passes the accept cycle, in which every cell shifts or writes at
//  once and the first level of the read-out tree is captured, and then the
//  gather cycle that loads the output register from the second tree level.
//  No new request is taken until the gather cycle has loaded the response.
//  A stalled output holds the gather cycle; req_tready is low until it ends.
//  Reset clears the count and sets max_entries to 64; no clearing pass, the
//  cells are undefined until written. csr writes are always taken.
//
module positional_list_store_unit #(
   parameter int CAPACITY   = plsu_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = plsu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] mode
   input  logic [39:0] req_tdata,   // [6:0] position, [38:7] entry_value, [39] zero
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [0] ok, [32:1] read_value,
                                    // [39:33] entry_count, [40] is_empty, [47:41] zero
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // max_entries
);

   localparam int POS_W   = plsu_pkg::POS_W;
   localparam int ENTRY_W = plsu_pkg::ENTRY_W;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int GS      = plsu_pkg::GROUP_SIZE;
   localparam int GRP_W   = $clog2(plsu_pkg::GROUP_SIZE);
   localparam int NG_W    = (CAPACITY > GS) ? $clog2((CAPACITY + GS - 1) / GS) : 1;
   localparam int TREE_W  = NG_W + GRP_W;

   plsu_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [6:0]             max_entries_ff;
   logic                   pend_ok_ff, pend_rd_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_empty_ff;
   logic [ENTRY_W-1:0]     rsp_value_ff;
   logic [6:0]             rsp_count_ff;

   logic                   accept, rsp_load;
   logic [2:0]             mode;
   logic [POS_W-1:0]       position;
   logic [ENTRY_W-1:0]     entry_value;
   logic [CMP_W-1:0]       pos_ext, count_ext, max_ext, cap_ext, limit, idx;
   logic                   pos_ok, ins_ok, ok_now, rd_now;
   logic [DATA_WIDTH-1:0]  word;
   logic [DATA_WIDTH-1:0]  tree_word;
   logic [ENTRY_W-1:0]     tree_value;
   plsu_pkg::cell_cmd_type cmd;
   logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];

   assign mode        = req_tuser;
   assign position    = req_tdata[6:0];
   assign entry_value = req_tdata[38:7];

   assign req_tready = (state_ff == plsu_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // position checks against count and the effective limit
   assign pos_ext   = CMP_W'(position);
   assign count_ext = CMP_W'(count_ff);
   assign max_ext   = CMP_W'(max_entries_ff);
   assign cap_ext   = CMP_W'(CAPACITY);
   assign limit     = (max_ext > cap_ext) ? cap_ext : max_ext;
   assign idx       = pos_ext - CMP_W'(1);
   assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_ext);
   assign ins_ok    = (pos_ext != '0) && (pos_ext <= count_ext + CMP_W'(1))
                      && (count_ext < limit);

   // operation decode
   always_comb begin
      ok_now   = 1'b0;
      rd_now   = 1'b0;
      count_in = count_ff;
      cmd      = '0;
      case (mode)
         plsu_pkg::MODE_INSERT: begin
            ok_now        = ins_ok;
            cmd.do_insert = accept && ins_ok;
            if (accept && ins_ok) count_in = count_ff + CNT_W'(1);
         end
         plsu_pkg::MODE_REMOVE: begin
            ok_now        = pos_ok;
            cmd.do_remove = accept && pos_ok;
            if (accept && pos_ok) count_in = count_ff - CNT_W'(1);
         end
         plsu_pkg::MODE_READ: begin
            ok_now = pos_ok;
            rd_now = pos_ok;
         end
         plsu_pkg::MODE_REPLACE: begin
            ok_now       = pos_ok;
            rd_now       = pos_ok;
            cmd.do_write = accept && pos_ok;
         end
         plsu_pkg::MODE_CLEAR: begin
            ok_now = 1'b1;
            if (accept) count_in = '0;
         end
         default: begin
            ok_now = 1'b0;
         end
      endcase
   end

   // new word fitted to the cell width
   if (DATA_WIDTH > ENTRY_W) begin : g_word_wide
      assign word       = {{(DATA_WIDTH - ENTRY_W){1'b0}}, entry_value};
      assign tree_value = tree_word[ENTRY_W-1:0];
   end else if (DATA_WIDTH == ENTRY_W) begin : g_word_same
      assign word       = entry_value;
      assign tree_value = tree_word;
   end else begin : g_word_narrow
      assign word       = entry_value[DATA_WIDTH-1:0];
      assign tree_value = {{(ENTRY_W - DATA_WIDTH){1'b0}}, tree_word};
   end

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data, right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      plsu_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (CMP_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .idx        (idx),
         .word       (word),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   // read-out tree, captured before the cells change
   plsu_gather #(
      .DATA_WIDTH (DATA_WIDTH),
      .CAPACITY   (CAPACITY),
      .NG_W       (NG_W)
   ) u_gather (
      .clock (clock),
      .load  (accept),
      .cells (cell_data),
      .idx   (idx[TREE_W-1:0]),
      .word  (tree_word)
   );

   // sequencer and output register control
   assign rsp_load = (state_ff == plsu_pkg::ST_GATHER) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plsu_pkg::ST_IDLE:   if (accept) state_in = plsu_pkg::ST_GATHER;
         plsu_pkg::ST_GATHER: if (rsp_load) state_in = plsu_pkg::ST_IDLE;
         default:             state_in = plsu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= plsu_pkg::ST_IDLE;
         count_ff       <= '0;
         max_entries_ff <= plsu_pkg::MAX_ENTRIES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) max_entries_ff <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ok_ff <= ok_now;
         pend_rd_ff <= rd_now;
      end
      if (rsp_load) begin
         rsp_ok_ff    <= pend_ok_ff;
         rsp_value_ff <= pend_rd_ff ? tree_value : '0;
         rsp_count_ff <= 7'(count_ff);
         rsp_empty_ff <= (count_ff == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_empty_ff, rsp_count_ff, rsp_value_ff, rsp_ok_ff};

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_gather: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == plsu_pkg::ST_GATHER))
      else $error("accepted item did not enter gather");

   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !ok_now) |=> (count_ff == $past(count_ff)))
      else $error("rejected item changed the count");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && ok_now && (mode == plsu_pkg::MODE_INSERT))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not bump the count");

   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_tvalid && (state_ff == plsu_pkg::ST_IDLE)))
      else $error("response load left sequencer busy");

endmodule

FILE: verif/plsu_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// plsu_checker
// Watches the req, rsp and csr channels of the positional list store unit.
// Every accepted request is run through a local copy of the list. The
// result it should give is queued. Each accepted response is compared
// field by field with the oldest queued result.
// ============================================================================
module plsu_checker
   import plsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [2:0]  req_tuser,    // [2:0] mode
   input  logic [39:0] req_tdata,    // [6:0] position, [38:7] entry_value, [39] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,    // [0] ok, [32:1] read_value,
                                     // [39:33] entry_count, [40] is_empty
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [6:0]  csr_data,     // max_entries
   output int          mismatch_count,
   output int          results_pending,
   output int          list_length
);

   // Response fields, MSB first so that the struct overlays rsp_tdata[40:0]
   typedef struct packed {
      logic                   is_empty;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [ENTRY_W-1:0]     read_value;
      logic                   ok;
   } list_reply_type;

   // Local copy of the list and its limit
   logic [ENTRY_W-1:0]       slot_word [CAPACITY_DEFAULT];
   int unsigned              fill;
   logic [MAX_ENTRIES_W-1:0] size_cap_reg;
   list_reply_type           reply_q [$];

   // Apply one request to the local list and return the reply it gives
   function automatic list_reply_type apply_list_op(input logic [MODE_W-1:0] mode,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [ENTRY_W-1:0] word);
      list_reply_type reply;
      int unsigned room;
      reply = '0;
      room  = (size_cap_reg > CAPACITY_DEFAULT) ? CAPACITY_DEFAULT : size_cap_reg;
      case (mode)
         MODE_INSERT: begin
            if (pos >= 1 && pos <= fill + 1 && fill < room) begin
               for (int i = fill; i >= pos; i--)
                  slot_word[i] = slot_word[i-1];
               slot_word[pos-1] = word;
               fill++;
               reply.ok = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (pos >= 1 && pos <= fill) begin
               for (int i = pos; i < fill; i++)
                  slot_word[i-1] = slot_word[i];
               fill--;
               reply.ok = 1'b1;
            end
         end
         MODE_READ: begin
            if (pos >= 1 && pos <= fill) begin
               reply.read_value = slot_word[pos-1];
               reply.ok         = 1'b1;
            end
         end
         MODE_REPLACE: begin
            if (pos >= 1 && pos <= fill) begin
               reply.read_value = slot_word[pos-1];
               slot_word[pos-1] = word;
               reply.ok         = 1'b1;
            end
         end
         MODE_CLEAR: begin
            fill     = 0;
            reply.ok = 1'b1;
         end
         default: ;  // spare codes change nothing
      endcase
      reply.entry_count = fill[COUNT_OUT_W-1:0];
      reply.is_empty    = (fill == 0);
      return reply;
   endfunction

   // Report one field that differs
   task automatic check_field(input string label, input logic [31:0] want_v,
                              input logic [31:0] got_v, inout bit bad);
      if (got_v !== want_v) begin
         $display("%0t ns: rsp %s mismatch, expected %h, actual %h",
                  $time, label, want_v, got_v);
         bad = 1'b1;
      end
   endtask

   // Track all three channels at each edge
   always @(posedge clock) begin
      list_reply_type want;
      list_reply_type got;
      bit             bad;
      if (reset) begin
         fill           = 0;
         size_cap_reg   = MAX_ENTRIES_RESET;
         mismatch_count = 0;
         reply_q.delete();
      end else begin
         // response first: it always belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[40:0];
            if (reply_q.size() == 0) begin
               $display("%0t ns: rsp item with none expected, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = reply_q.pop_front();
               bad  = 1'b0;
               check_field("ok", want.ok, got.ok, bad);
               check_field("read_value", want.read_value, got.read_value, bad);
               check_field("entry_count", want.entry_count, got.entry_count, bad);
               check_field("is_empty", want.is_empty, got.is_empty, bad);
               if (bad)
                  mismatch_count++;
            end
         end
         if (req_tvalid && req_tready)
            reply_q.push_back(apply_list_op(req_tuser, req_tdata[6:0], req_tdata[38:7]));
         if (csr_valid && csr_ready)
            size_cap_reg = csr_data;
      end
      results_pending <= reply_q.size();
      list_length     <= fill;
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stimulus for the positional list store unit. A directed opening covers
// the edges of each operation. Random phases follow under several list
// limits, with bursts of idling on both channels. The checker beside the
// block does the prediction, and this module gives the verdict.
// ============================================================================
module tb_top;
   import plsu_pkg::*;

   // Spare operation codes that the block must ignore
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = '0;   // [2:0] mode
   logic [39:0] req_tdata  = '0;   // [6:0] position, [38:7] entry_value, [39] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [0] ok, [32:1] read_value,
                                   // [39:33] entry_count, [40] is_empty
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data   = '0;   // max_entries

   int mismatch_count;
   int results_pending;
   int list_length;

   // Idle odds in percent per item or per cycle; zero turns idling off
   int gap_odds   = 25;
   int stall_odds = 25;

   positional_list_store_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   plsu_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .list_length     (list_length)
   );

   // 100 MHz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("positional_list_store_unit regression: fail");
      $finish;
   end

   // Response side: random stall bursts
   initial begin
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Present one request and hold it until it is taken
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                            input logic [ENTRY_W-1:0] word);
      if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, word, pos};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and wait until every response is back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // Set the list limit while the block is idle
   task automatic write_cap(input logic [MAX_ENTRIES_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Random requests, mostly at positions that are valid for the list's size
   task automatic run_burst(input int n, input int ins_pct, input int rem_pct,
                            input int clr_pct);
      logic [MODE_W-1:0]  mode;
      logic [POS_W-1:0]   pos;
      logic [ENTRY_W-1:0] word;
      int                 roll;
      int                 len;
      for (int k = 0; k < n; k++) begin
         len = list_length;
         case ($urandom_range(0, 9))
            0:       word = '0;
            1:       word = '1;
            default: word = $urandom;
         endcase
         if ($urandom_range(0, 99) < 6) begin
            // noise over the whole field ranges
            mode = MODE_W'($urandom_range(0, 7));
            pos  = POS_W'($urandom_range(0, 127));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
               mode = MODE_INSERT;
            else if (roll < ins_pct + rem_pct)
               mode = MODE_REMOVE;
            else if (roll >= 100 - clr_pct)
               mode = MODE_CLEAR;
            else if (roll[0])
               mode = MODE_READ;
            else
               mode = MODE_REPLACE;
            if ($urandom_range(0, 9) == 0) begin
               // just past either end, or far out
               case ($urandom_range(0, 3))
                  0:       pos = '0;
                  1:       pos = POS_W'(len + 1);
                  2:       pos = POS_W'(len + 2);
                  default: pos = '1;
               endcase
            end else if (mode == MODE_INSERT) begin
               pos = POS_W'($urandom_range(1, len + 1));
            end else begin
               pos = POS_W'($urandom_range(1, (len > 0) ? len : 1));
            end
         end
         send_item(mode, pos, word);
      end
   endtask

   // Main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, inserts at front, middle and end, edges of each op
      send_item(MODE_READ, 1, 32'h0);
      send_item(MODE_REMOVE, 0, 32'h0);
      send_item(MODE_INSERT, 0, 32'hDEAD_BEEF);
      send_item(MODE_INSERT, 2, 32'hDEAD_BEEF);
      send_item(MODE_INSERT, 1, 32'h0000_0000);
      send_item(MODE_INSERT, 1, 32'hFFFF_FFFF);
      send_item(MODE_INSERT, 3, 32'hA5A5_A5A5);
      send_item(MODE_INSERT, 2, 32'h1234_5678);
      for (int p = 1; p <= 5; p++)
         send_item(MODE_READ, POS_W'(p), 32'h0);
      send_item(MODE_READ, 127, 32'h0);
      send_item(MODE_REPLACE, 4, 32'h5A5A_5A5A);
      send_item(MODE_REPLACE, 0, 32'hFFFF_FFFF);
      send_item(MODE_REPLACE, 5, 32'hFFFF_FFFF);
      send_item(MODE_REMOVE, 2, 32'h0);
      send_item(MODE_REMOVE, 4, 32'h0);
      send_item(MODE_READ, 2, 32'h0);
      send_item(MODE_SPARE_LO, 1, 32'hFFFF_FFFF);
      send_item(MODE_SPARE_HI, 127, 32'hFFFF_FFFF);
      send_item(MODE_CLEAR, 0, 32'h0);
      send_item(MODE_READ, 1, 32'h0);
      send_item(MODE_CLEAR, 127, 32'hFFFF_FFFF);

      // Fill up to the full limit and run against it
      write_cap(7'd64);
      run_burst(300, 55, 15, 0);

      // Limit dropped below the current count
      write_cap(7'd3);
      run_burst(100, 30, 35, 1);

      // Zero limit: every insert is turned away
      write_cap(7'd0);
      run_burst(60, 40, 20, 5);

      // Limit above capacity is clamped
      write_cap(7'd127);
      run_burst(250, 50, 20, 1);

      // Single-entry list
      write_cap(7'd1);
      run_burst(100, 40, 30, 3);

      // Random limit, response side never stalls
      stall_odds = 0;
      gap_odds   = 15;
      write_cap(MAX_ENTRIES_W'($urandom_range(2, 63)));
      run_burst(250, 40, 35, 2);

      // Closing stretch at full speed
      gap_odds = 0;
      write_cap(7'd64);
      run_burst(200, 45, 30, 2);

      wait_idle();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0)
         $display("positional_list_store_unit regression: pass");
      else
         $display("positional_list_store_unit regression: fail");
      $finish;
   end

endmodule
